@@ rtl/core/tghs_pkg.sv @@
// Package with shared types and constants for the terrain grid height sampler.
`timescale 1ns / 1ps
package tghs_pkg;

    localparam int MAX_WIDTH = 128;
    localparam int MAX_DEPTH = 128;
    localparam int X_W       = $clog2(MAX_WIDTH);
    localparam int Z_W       = $clog2(MAX_DEPTH);
    localparam int ADDR_W    = X_W + Z_W;
    localparam int CFG_IDX_W = 3;

    // Widths of the input and output tdata words.
    localparam int IN_DATA_W = 112;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_SAMPLE = 2'd2
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_W   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_D   = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WR,
        ST_VRD,
        ST_VOUT,
        ST_MULX,
        ST_MULZ,
        ST_CHECK,
        ST_WGT,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_FINAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       load_in;
        logic       mul_x;
        logic       mul_z;
        logic       check;
        logic       wgt;
        logic       rd_vertex;
        logic       rd_corner;
        logic [1:0] corner;
        logic       mul_corner;
        logic       acc;
        logic       wr_vertex;
        logic       res_write;
        logic       res_vread;
        logic       res_err;
        logic       res_final;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       sample_ok;
    } t_dp_sts;

endpackage

@@ rtl/core/tghs_ctrl.sv @@
// Controller state machine that sequences the sampler datapath.
`timescale 1ns / 1ps
module tghs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output tghs_pkg::t_dp_cmd o_cmd,
    input  tghs_pkg::t_dp_sts i_sts
);
    import tghs_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        o_cmd         = '0;
        o_cmd.corner  = r_k;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_sts.op)
                    OP_WRITE:  n_state = ST_WR;
                    OP_READ:   n_state = ST_VRD;
                    OP_SAMPLE: n_state = ST_MULX;
                    default: begin
                        o_cmd.res_err = 1'b1;
                        n_state       = ST_DONE;
                    end
                endcase
            end
            ST_WR: begin
                o_cmd.wr_vertex = 1'b1;
                o_cmd.res_write = 1'b1;
                n_state         = ST_DONE;
            end
            ST_VRD: begin
                o_cmd.rd_vertex = 1'b1;
                n_state         = ST_VOUT;
            end
            ST_VOUT: begin
                o_cmd.res_vread = 1'b1;
                n_state         = ST_DONE;
            end
            ST_MULX: begin
                o_cmd.mul_x = 1'b1;
                n_state     = ST_MULZ;
            end
            ST_MULZ: begin
                o_cmd.mul_z = 1'b1;
                n_state     = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = ST_WGT;
            end
            ST_WGT: begin
                if (i_sts.sample_ok) begin
                    o_cmd.wgt = 1'b1;
                    n_k       = 2'd0;
                    n_state   = ST_RD;
                end else begin
                    o_cmd.res_err = 1'b1;
                    n_state       = ST_DONE;
                end
            end
            ST_RD: begin
                o_cmd.rd_corner = 1'b1;
                n_state         = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_corner = 1'b1;
                n_state          = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_k == 2'd3) begin
                    n_state = ST_FINAL;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_RD;
                end
            end
            ST_FINAL: begin
                o_cmd.res_final = 1'b1;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = (r_out_valid && !m_axis_tready) || o_cmd.out_load;
    end

    assign m_axis_tvalid = r_out_valid;

endmodule

@@ rtl/core/tghs_dp.sv @@
// Datapath of the sampler: configuration, vertex memory, multipliers and result registers.
`timescale 1ns / 1ps
module tghs_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [tghs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    input  logic [tghs_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic [1:0]                         i_in_op,
    output logic [tghs_pkg::OUT_DATA_W-1:0]    o_out_data,
    output logic                               o_out_status,
    input  tghs_pkg::t_dp_cmd                  i_cmd,
    output tghs_pkg::t_dp_sts                  o_sts
);
    import tghs_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [6:0]  cidx;
        logic [16:0] frac;
    } t_axis;

    // Configuration registers.
    logic signed [31:0] r_org_x, r_org_z, r_org_y;
    logic [31:0]        r_inv;
    logic [7:0]         r_gw, r_gd;

    // Captured item.
    logic [1:0]         r_op;
    logic [X_W-1:0]     r_vx;
    logic [Z_W-1:0]     r_vz;
    logic signed [31:0] r_hin, r_wx, r_wz;

    logic [31:0] mem [MAX_WIDTH*MAX_DEPTH];
    logic signed [31:0] r_rd;

    logic [63:0] r_gx, r_gz;
    logic        r_negx, r_negz;
    logic [6:0]  r_cx, r_cz;
    logic [16:0] r_fx, r_fz;
    logic        r_ok;
    logic [16:0] r_w [4];
    logic signed [49:0] r_prod, r_acc;
    logic        r_res_status;
    logic [31:0] r_res_h;
    logic        r_out_status;
    logic [31:0] r_out_h;

    logic [7:0]  eff_w, eff_d;
    logic        in_range;
    logic signed [32:0] dx, dz;
    logic [31:0] mul_a;
    logic [63:0] mul_p;
    t_axis       ax, az;
    logic [6:0]  corner_x, corner_z;
    logic [ADDR_W-1:0] rd_addr;
    logic signed [49:0] cprod;
    logic signed [49:0] rnd;
    logic signed [34:0] sum_y;
    logic [31:0] sat_h;
    logic [17:0] xz;

    function automatic t_axis to_cell(input logic neg, input logic [63:0] gp,
                                      input logic [7:0] dim);
        logic [47:0] g;
        logic [47:0] lim;
        logic [7:0]  dm1;
        logic [7:0]  dm2;
        logic        clamp;
        t_axis       res;
        g     = gp[63:16];
        dm1   = dim - 8'd1;
        dm2   = dim - 8'd2;
        lim   = 48'({dm1, 16'h0000});
        clamp = g[47:16] > 32'(dm2);
        res.ok   = !neg && (g <= lim);
        res.cidx = clamp ? dm2[6:0] : g[22:16];
        res.frac = clamp ? 17'h10000 : {1'b0, g[15:0]};
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_z <= '0;
            r_org_y <= '0;
            r_inv   <= 32'd65536;
            r_gw    <= 8'd128;
            r_gd    <= 8'd128;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                CFG_ORIGIN_Z: r_org_z <= i_cfg_data;
                CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                CFG_INV_CELL: r_inv   <= i_cfg_data;
                CFG_GRID_W:   r_gw    <= i_cfg_data[7:0];
                CFG_GRID_D:   r_gd    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign eff_w = (r_gw < 8'd2) ? 8'd2 : ((r_gw > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : r_gw);
    assign eff_d = (r_gd < 8'd2) ? 8'd2 : ((r_gd > 8'(MAX_DEPTH)) ? 8'(MAX_DEPTH) : r_gd);
    assign in_range = ({1'b0, r_vx} < eff_w) && ({1'b0, r_vz} < eff_d);

    assign dx    = {r_wx[31], r_wx} - {r_org_x[31], r_org_x};
    assign dz    = {r_wz[31], r_wz} - {r_org_z[31], r_org_z};
    assign mul_a = i_cmd.mul_z ? dz[31:0] : dx[31:0];
    assign mul_p = mul_a * r_inv;

    assign ax = to_cell(r_negx, r_gx, eff_w);
    assign az = to_cell(r_negz, r_gz, eff_d);

    assign corner_x = r_cx + {6'd0, i_cmd.corner[0]};
    assign corner_z = r_cz + {6'd0, i_cmd.corner[1]};
    assign rd_addr  = i_cmd.rd_corner ? {corner_z, corner_x} : {r_vz, r_vx};

    assign cprod = $signed(r_rd) * $signed({1'b0, r_w[i_cmd.corner]});

    // Round half up, floor shift, then add the height offset with saturation.
    assign rnd   = r_acc + 50'sd32768;
    assign sum_y = {rnd[49], rnd[49:16]} + {{3{r_org_y[31]}}, r_org_y};
    assign sat_h = (sum_y[34:31] == 4'b0000 || sum_y[34:31] == 4'b1111) ? sum_y[31:0]
                 : (sum_y[34] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign xz    = {1'b0, r_fx} + {1'b0, r_fz};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_in_op;
            r_vx  <= i_in_data[6:0];
            r_vz  <= i_in_data[13:7];
            r_hin <= i_in_data[45:14];
            r_wx  <= i_in_data[77:46];
            r_wz  <= i_in_data[109:78];
        end
        if (i_cmd.wr_vertex && in_range) begin
            mem[{r_vz, r_vx}] <= r_hin;
        end
        if (i_cmd.rd_vertex || i_cmd.rd_corner) begin
            r_rd <= mem[rd_addr];
        end
        if (i_cmd.mul_x) begin
            r_gx   <= mul_p;
            r_negx <= dx[32];
        end
        if (i_cmd.mul_z) begin
            r_gz   <= mul_p;
            r_negz <= dz[32];
        end
        if (i_cmd.check) begin
            r_ok <= ax.ok && az.ok;
            r_cx <= ax.cidx;
            r_cz <= az.cidx;
            r_fx <= ax.frac;
            r_fz <= az.frac;
        end
        if (i_cmd.wgt) begin
            r_acc <= '0;
            // Corner order: (0,0), (1,0), (0,1), (1,1).
            if ((r_cx[0] ^ r_cz[0]) == 1'b0) begin
                if (r_fx >= r_fz) begin
                    r_w[0] <= 17'h10000 - r_fx;
                    r_w[1] <= r_fx - r_fz;
                    r_w[2] <= '0;
                    r_w[3] <= r_fz;
                end else begin
                    r_w[0] <= 17'h10000 - r_fz;
                    r_w[1] <= '0;
                    r_w[2] <= r_fz - r_fx;
                    r_w[3] <= r_fx;
                end
            end else if (xz <= 18'h10000) begin
                r_w[0] <= 17'(18'h10000 - xz);
                r_w[1] <= r_fx;
                r_w[2] <= r_fz;
                r_w[3] <= '0;
            end else begin
                r_w[0] <= '0;
                r_w[1] <= 17'h10000 - r_fz;
                r_w[2] <= 17'h10000 - r_fx;
                r_w[3] <= 17'(xz - 18'h10000);
            end
        end
        if (i_cmd.mul_corner) begin
            r_prod <= cprod;
        end
        if (i_cmd.acc) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.res_write) begin
            r_res_status <= !in_range;
            r_res_h      <= '0;
        end
        if (i_cmd.res_vread) begin
            r_res_status <= !in_range;
            r_res_h      <= in_range ? r_rd : 32'd0;
        end
        if (i_cmd.res_err) begin
            r_res_status <= 1'b1;
            r_res_h      <= '0;
        end
        if (i_cmd.res_final) begin
            r_res_status <= 1'b0;
            r_res_h      <= sat_h;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_h      <= r_res_h;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.sample_ok = r_ok;
    assign o_out_data      = r_out_h;
    assign o_out_status    = r_out_status;

endmodule

@@ rtl/core/terrain_grid_height_sampler_top.sv @@
// Top level of the terrain grid height sampler.
`timescale 1ns / 1ps
// The block keeps a 128 by 128 grid of signed Q16.16 vertex heights and takes
// one command word at a time on the slave stream: tuser carries the opcode
// (write vertex, read vertex, sample world point) and tdata the operands.
// Every command word gives exactly one result word on the master stream:
// tuser is the status flag (1 for out of range, point outside the grid or
// unused opcode) and tdata the height.
// Configuration registers are written through a separate valid/ready
// channel that is always ready; write them only while the block is idle.
// A sample reads its four cell corners one after another through the single
// port of the vertex memory, each corner followed by a multiply and an
// accumulate; before that, a 32 by 32 multiplier shared by both axes maps
// the world point into the grid. The next word can be accepted in the cycle
// after its predecessor's result is handed to the output register.
// Synchronous reset returns the controller to idle, drops the output valid
// and restores the configuration defaults; the vertex memory is not cleared
// and must be written before it is read. When the receiver stalls, the
// finished result waits in the output register while the next word can
// already be accepted and processed up to its own result.
module terrain_grid_height_sampler_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tghs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    // Command stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: vertex_x[6:0], vertex_z[13:7], height_in[45:14],
    // world_x[77:46], world_z[109:78], zero pad [111:110]
    input  logic [tghs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: op[1:0]
    input  logic [1:0]                         s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: height_out[31:0]
    output logic [tghs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: status[0]
    output logic                               m_axis_tuser
);
    import tghs_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    tghs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (cmd),
        .i_sts         (sts)
    );

    tghs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_data    (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

endmodule
